[rtl/udpc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// udpc_pkg
// Shared types, constants and the ones' complement fold for the UDP checksum.
// ---------------------------------------------------------------------------
package udpc_pkg;

  localparam logic [15:0] UDP_PROTOCOL = 16'd17;
  // header byte index of the UDP length low byte
  localparam logic [2:0]  LEN_LO_POS   = 3'd5;
  localparam logic [2:0]  POS_LIMIT    = 3'd7;

  // one registered input beat, pseudo-header already folded
  typedef struct packed {
    logic [7:0]  data;
    logic        eop;
    logic [15:0] pseudo;
  } udpc_beat_t;

  // end-around carry fold of a sum of up to eight 16-bit words
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] f1;
    f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    return f1[15:0] + {15'd0, f1[16]};
  endfunction

endpackage
`default_nettype wire

[rtl/udpc_in_stage.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// udpc_in_stage
// Input register; folds the pseudo-header words on the way in.
// ---------------------------------------------------------------------------
module udpc_in_stage import udpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic        in_end_of_packet,
  input  wire logic        take,
  output logic             beat_valid,
  output udpc_beat_t       beat
);

  logic       beat_valid_r, beat_valid_nxt;
  udpc_beat_t beat_r, beat_nxt;
  logic       accept;
  logic [18:0] ph_sum;

  assign in_stall = beat_valid_r & ~take;
  assign accept   = in_valid & ~in_stall;

  assign ph_sum = {3'd0, in_source_address[31:16]} + {3'd0, in_source_address[15:0]}
                + {3'd0, in_destination_address[31:16]}
                + {3'd0, in_destination_address[15:0]} + {3'd0, UDP_PROTOCOL};

  always_comb begin
    beat_valid_nxt = accept | (beat_valid_r & ~take);
    beat_nxt       = beat_r;
    if (accept) begin
      beat_nxt.data   = in_data_byte;
      beat_nxt.eop    = in_end_of_packet;
      beat_nxt.pseudo = oc_fold(ph_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else begin
      beat_valid_r <= beat_valid_nxt;
    end
    beat_r <= beat_nxt;
  end

  assign beat_valid = beat_valid_r;
  assign beat       = beat_r;

endmodule
`default_nettype wire

[rtl/udpc_sum.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// udpc_sum
// Running ones' complement sum, byte pairing and the result register.
// ---------------------------------------------------------------------------
module udpc_sum import udpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        beat_valid,
  input  wire udpc_beat_t  beat,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_checksum
);

  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        odd_r, odd_nxt;
  logic [2:0]  hp_r, hp_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] cks_r, cks_nxt;

  logic [15:0] base, add1, add2, new_sum;

  assign take = beat_valid & ~(out_valid_r & out_stall);

  always_comb begin
    base = (hp_r == 3'd0) ? beat.pseudo : sum_r;
    add1 = 16'd0;
    add2 = 16'd0;
    if (!odd_r) begin
      if (beat.eop) begin
        add1 = {beat.data, 8'd0};   // odd trailing byte, zero padded
      end
    end else begin
      add1 = {pend_r, beat.data};
      // length word counted twice: once in the datagram, once for the pseudo-header
      if (hp_r == LEN_LO_POS) begin
        add2 = {pend_r, beat.data};
      end
    end
    new_sum = oc_fold({3'd0, base} + {3'd0, add1} + {3'd0, add2});
  end

  always_comb begin
    sum_nxt       = sum_r;
    pend_nxt      = pend_r;
    odd_nxt       = odd_r;
    hp_nxt        = hp_r;
    cks_nxt       = cks_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (take) begin
      if (beat.eop) begin
        sum_nxt       = 16'd0;
        pend_nxt      = 8'd0;
        odd_nxt       = 1'b0;
        hp_nxt        = 3'd0;
        cks_nxt       = ~new_sum;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt  = new_sum;
        pend_nxt = odd_r ? pend_r : beat.data;
        odd_nxt  = ~odd_r;
        hp_nxt   = (hp_r < POS_LIMIT) ? hp_r + 3'd1 : hp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 16'd0;
      pend_r      <= 8'd0;
      odd_r       <= 1'b0;
      hp_r        <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      pend_r      <= pend_nxt;
      odd_r       <= odd_nxt;
      hp_r        <= hp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cks_r <= cks_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = cks_r;

endmodule
`default_nettype wire

[rtl/udp_checksum_pseudo_header.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// udp_checksum_pseudo_header
// Path: input register, then sum stage into the result register. Throughput:
//   one byte beat per cycle unless out_stall blocks a waiting checksum; the
//   per-byte sum update is a single three-word add and fold in the sum stage.
// Reset: synchronous, active low; clears the valid flags of both stages and
//   the packet state, so the next beat starts a new packet.
// ---------------------------------------------------------------------------
//
// Datapath:
//   udpc_in_stage - input register. The pseudo-header (source, destination,
//                   protocol 17) is folded into 16 bits before the register,
//                   so the address ports are only looked at on the beat that
//                   is taken; the sum stage uses the folded value only on
//                   the first beat of a packet.
//   udpc_sum      - pairs bytes into big-endian words, adds them into the
//                   running sum with end-around carry, adds the UDP length
//                   word a second time at header byte 5, pads an odd last
//                   byte with zero and loads the complemented sum into the
//                   result register.
// The result register frees the input side: a new beat is taken while a
// checksum waits, and in_stall rises only when the input register is full
// and a waiting checksum is blocked by out_stall.
module udp_checksum_pseudo_header import udpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic        in_end_of_packet,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_checksum
);

  logic       beat_valid;
  udpc_beat_t beat;
  logic       take;

  udpc_in_stage u_in_stage (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_byte           (in_data_byte),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_end_of_packet       (in_end_of_packet),
    .take                   (take),
    .beat_valid             (beat_valid),
    .beat                   (beat)
  );

  udpc_sum u_sum (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_valid   (beat_valid),
    .beat         (beat),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

endmodule
`default_nettype wire

[rtl/udpc_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// udpc_checker
// Port-level checks for the UDP checksum block, bound to the top level.
// ---------------------------------------------------------------------------
module udpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_checksum
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum))
    else $error("checksum beat dropped or changed while stalled");

  // input back-pressure only comes from a blocked result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // nothing emitted right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a free output side never stalls the input
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

endmodule

bind udp_checksum_pseudo_header udpc_checker u_udpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_checksum (out_checksum)
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - UDP checksum with IPv4 pseudo-header
// Streams datagrams byte by byte into udp_checksum_pseudo_header. Every
// checksum is compared with a cycle-free ones' complement model kept here,
// or a typed row's hand-worked value. A fixed table covers corners; random
// packets follow under random sender bursts and receiver stall patterns.
// ---------------------------------------------------------------------------
module tb;
  import udpc_pkg::*;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // one row of the directed table; typed rows carry a hand-worked checksum
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] src;
    logic [31:0] dst;
    logic        eop;
    logic        typed;
    logic [15:0] chk;
  } dir_beat_t;

  localparam int N_DIR      = 26;
  localparam int N_ITEMS    = 1250;
  localparam int LONG_HOLD  = 400;   // receiver hold-off, cycles
  localparam int DRAIN_WAIT = 8;     // latency through both registers plus margin

  // corner packets
  //   one zero byte, zero addresses: sum is just protocol 17
  //   two bytes plus protocol 17 make 0xFFFF: zero checksum goes out unmapped
  //   all-ones addresses, single 0xFF byte: every pseudo-header add carries around
  //   an 8-byte header: length word counted twice
  //   a 5-byte packet: ends before the length low byte
  //   a 6-byte packet: ends right on the length low byte
  //   a 3-byte packet: odd tail padded with zero
  // Addresses on later bytes are junk; only the first byte samples them.
  localparam dir_beat_t DIR_TAB [N_DIR] = '{
    '{8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 16'hFFEE},
    '{8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'hEE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000},
    '{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h00EE},
    '{8'h04, 32'hC0A8_0001, 32'hC0A8_00C7, 1'b0, 1'b0, 16'h0000},
    '{8'hD2, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'h35, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 16'h0000},
    '{8'h08, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1, 1'b0, 16'h0000},
    '{8'h12, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0000},
    '{8'h34, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'h56, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
    '{8'h78, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'h9A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000},
    '{8'hAB, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
    '{8'hCD, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'hEF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'h01, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000},
    '{8'h00, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 32'hCAFE_F00D, 32'h0BAD_CAFE, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic [31:0] in_source_address = 32'h0;
  logic [31:0] in_destination_address = 32'h0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_checksum;

  // hand-worked checksum travelling with the beat on the wire
  logic        cur_typed = 1'b0;
  logic [15:0] cur_typed_chk = 16'h0;

  // checksum model state
  logic [15:0] acc_sum = 16'h0;
  logic [7:0]  hi_byte = 8'h0;
  logic        hi_held = 1'b0;
  logic [2:0]  byte_idx = 3'd0;

  logic [15:0] csum_q[$];        // checksums owed by the block, oldest first
  int          errors = 0;
  int          beats_taken = 0;
  int          csums_checked = 0;
  int          zero_csums = 0;
  int          beats_sent = 0;
  int          pkts_sent = 0;
  int          short_pkts = 0;

  // sender / receiver control
  bit          gaps_on = 1'b0;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [3:0]  stall_tick = 4'd0;
  bit          stalled_in = 1'b0;   // input side was pushed back at least once

  udp_checksum_pseudo_header i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_byte           (in_data_byte),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_end_of_packet       (in_end_of_packet),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_checksum           (out_checksum)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Advance the checksum model by one byte. The pseudo-header is summed on
  // the first byte; bytes pair into big-endian words; the word that ends at
  // header byte 5 (UDP length) goes in twice; a lone last byte is the high
  // half of a zero-padded word.
  function automatic void udp_sum_byte(input logic [7:0] d, input logic [31:0] src,
                                       input logic [31:0] dst, input logic last,
                                       output bit emits, output logic [15:0] csum);
    logic [15:0] word;
    if (byte_idx == 3'd0) begin
      acc_sum = ones_add(src[31:16], src[15:0]);
      acc_sum = ones_add(acc_sum, dst[31:16]);
      acc_sum = ones_add(acc_sum, dst[15:0]);
      acc_sum = ones_add(acc_sum, UDP_PROTOCOL);
    end
    if (!hi_held) begin
      hi_byte = d;
      hi_held = 1'b1;
      if (last) acc_sum = ones_add(acc_sum, {d, 8'h00});
    end else begin
      word = {hi_byte, d};
      acc_sum = ones_add(acc_sum, word);
      if (byte_idx == LEN_LO_POS) acc_sum = ones_add(acc_sum, word);
      hi_held = 1'b0;
    end
    if (byte_idx < POS_LIMIT) byte_idx = byte_idx + 3'd1;
    emits = last;
    csum = ~acc_sum;
    if (last) begin
      acc_sum = 16'h0;
      hi_byte = 8'h0;
      hi_held = 1'b0;
      byte_idx = 3'd0;
    end
  endfunction

  // Monitor: both handshakes are sampled at the edge where they complete.
  // Output is checked before the input beat is folded in; a checksum never
  // leaves on the edge its last byte is taken, so the order is free.
  always @(posedge clk) begin : mon
    bit          emits;
    logic [15:0] csum;
    logic [15:0] want;
    if (rst_n) begin
      if (in_valid && in_stall) stalled_in = 1'b1;
      if (out_valid && !out_stall) begin
        if (csum_q.size() == 0) begin
          errors++;
          $display("%0t: checksum mismatch: expected none, actual %h", $time, out_checksum);
        end else begin
          want = csum_q.pop_front();
          csums_checked++;
          if (out_checksum === 16'h0000) zero_csums++;
          if (out_checksum !== want) begin
            errors++;
            $display("%0t: checksum mismatch: expected %h, actual %h",
                     $time, want, out_checksum);
          end
        end
      end
      if (in_valid && !in_stall) begin
        beats_taken++;
        udp_sum_byte(in_data_byte, in_source_address, in_destination_address,
                     in_end_of_packet, emits, csum);
        if (emits) csum_q.push_back(cur_typed ? cur_typed_chk : csum);
      end
    end
  end

  // Receiver: a long hold-off when the token moves, otherwise the current pattern.
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_tick <= stall_tick + 4'd1;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (stall_tick[3:2] == 2'b11);
      endcase
    end
  end

  // Offer one beat and hold it until taken. If gaps are on and the current burst
  // is used up, a gap comes first; valid stays high between back-to-back beats.
  task automatic send_beat(input logic [7:0] d, input logic [31:0] src,
                           input logic [31:0] dst, input logic last,
                           input logic typed, input logic [15:0] tchk);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid               <= 1'b1;
    in_data_byte           <= d;
    in_source_address      <= src;
    in_destination_address <= dst;
    in_end_of_packet       <= last;
    cur_typed              <= typed;
    cur_typed_chk          <= tchk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    beats_sent++;
    if (last) pkts_sent++;
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random datagram; addresses on later bytes are junk the block must ignore.
  task automatic send_packet(input int len);
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  d;
    src = pick_addr();
    dst = pick_addr();
    if (len < 6) short_pkts++;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      if (i == 0) send_beat(d, src, dst, len == 1, 1'b0, 16'h0);
      else        send_beat(d, $urandom, $urandom, i == len - 1, 1'b0, 16'h0);
    end
  endtask

  // block until the block owes nothing; the first edge lets the monitor
  // book the beat taken on the current edge
  task automatic drain_results();
    @(posedge clk);
    while (csum_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stim
    int len;
    int pkt_no;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, back to back with a lightly stalling receiver
    rx_mode = RX_LIGHT;
    for (int r = 0; r < N_DIR; r++)
      send_beat(DIR_TAB[r].data, DIR_TAB[r].src, DIR_TAB[r].dst,
                DIR_TAB[r].eop, DIR_TAB[r].typed, DIR_TAB[r].chk);

    // sender pause: nothing new until every checksum is back
    in_valid <= 1'b0;
    drain_results();

    pkt_no = 0;
    while (beats_sent < N_ITEMS) begin
      if (pkt_no == 10) begin
        // long receiver hold-off against a flood of one-byte packets:
        // results pile up and the input side must push back
        gaps_on = 1'b0;
        rx_mode = RX_FREE;
        hold_token++;
        repeat (40) send_packet(1);
        in_valid <= 1'b0;
        drain_results();
      end
      if (pkt_no % 6 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 16);
        6, 7, 8:          len = $urandom_range(17, 64);
        default:          len = $urandom_range(1, 6);
      endcase
      send_packet(len);
      pkt_no++;
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d byte beats in %0d packets (%0d too short for the length word)",
             beats_taken, pkts_sent, short_pkts);
    $display("%0d checksums compared, %0d of them zero; input pushback seen: %0d",
             csums_checked, zero_csums, stalled_in);
    if (errors == 0) begin
      $display("[udp_checksum_pseudo_header] OK");
    end else begin
      $display("[udp_checksum_pseudo_header] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d checksums outstanding", csum_q.size());
    $display("[udp_checksum_pseudo_header] ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/udpc_pkg.sv
rtl/udpc_in_stage.sv
rtl/udpc_sum.sv
rtl/udp_checksum_pseudo_header.sv
rtl/udpc_checker.sv
bench/tb.sv
